// File: rtl/prrs_pkg.sv
package prrs_pkg;

  localparam int SLICE_W = 8;
  localparam int RUN_W = 32;
  localparam int SWITCH_W = 32;
  localparam logic [SLICE_W-1:0] RELOAD_AT_RESET = 8'd10;

  typedef enum logic [1:0] {
    OP_CREATE    = 2'd0,
    OP_TERMINATE = 2'd1,
    OP_TICK      = 2'd2,
    OP_YIELD     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TS_READY      = 2'd0,
    TS_RUNNING    = 2'd1,
    TS_TERMINATED = 2'd2
  } tstate_t;

  // One entry of the task table.
  typedef struct packed {
    tstate_t              state;
    logic [SLICE_W-1:0]   slice;
    logic [RUN_W-1:0]     run;
  } task_word_t;

endpackage

// File: rtl/prrs_ram.sv
module prrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/prrs_level_pick.sv
module prrs_level_pick #(
  parameter int LEVELS = 4,
  localparam int LVL_W = $clog2(LEVELS)
) (
  input  logic [LEVELS-1:0] nonempty,
  output logic [LVL_W-1:0]  level
);

  // The highest non-empty level wins; level 0 always holds the idle task.
  always_comb begin
    level = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (nonempty[i]) begin
        level = LVL_W'(i);
      end
    end
  end

endmodule

// File: rtl/priority_round_robin_scheduler_unit.sv
// Each accepted word walks the sequencer to S_DONE: create is done in S_DECODE, terminate
// adds S_TERM_WR, tick S_TICK_WR (then the yield states on expiry), yield S_PICK, S_ROTATE
// and, on a switch, S_OLD_WR (if a task was running) and S_NEW_WR. One item at a time; the
// next word is taken the cycle after a result is registered.
// Reset is synchronous and clears control registers only; memories are not swept, and the
// reset contents of slot 0 are supplied by two written-flags until first overwritten.
module priority_round_robin_scheduler_unit
  import prrs_pkg::*;
#(
  parameter int MAX_TASKS = 256,
  parameter int PRIORITY_LEVELS = 4,
  localparam int ID_W = $clog2(MAX_TASKS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [1:0]          priority_req,
  input  logic [ID_W-1:0]     task_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     created_id,
  output logic [ID_W-1:0]     running_id,
  output logic                switched,
  output logic [1:0]          status,
  output logic [SWITCH_W-1:0] switch_total,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int PTR_W = $clog2(MAX_TASKS);
  localparam int LVL_W = $clog2(PRIORITY_LEVELS);
  localparam int QA_W = $clog2(PRIORITY_LEVELS * MAX_TASKS);
  localparam int TW_W = $bits(task_word_t);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_TERM_WR, S_TICK_WR, S_PICK, S_ROTATE, S_OLD_WR, S_NEW_WR, S_DONE
  } fsm_t;

  fsm_t state;

  logic [SLICE_W-1:0]  slice_reload;
  logic [ID_W-1:0]     slot_count;
  logic [ID_W-1:0]     current;
  logic [SWITCH_W-1:0] switch_count;
  logic [PTR_W-1:0]    head [PRIORITY_LEVELS];
  logic [PTR_W-1:0]    tail [PRIORITY_LEVELS];
  logic [ID_W-1:0]     fill [PRIORITY_LEVELS];

  op_t              op_r;
  logic [LVL_W-1:0] prio_r;
  logic [ID_W-1:0]  tid_r;
  logic [ID_W-1:0]  created_r;
  status_t          status_r;
  logic             sw_r;
  logic [PTR_W-1:0] nxt_slot;
  logic [LVL_W-1:0] pick_lvl;

  // Slot 0 and queue entry 0 of level 0 have defined reset contents.
  logic t0_written;
  logic q0_written;
  logic rd_init;
  logic pick_init;

  logic             t_we;
  logic [PTR_W-1:0] t_waddr;
  task_word_t       t_wdata;
  logic [PTR_W-1:0] t_raddr;
  logic [TW_W-1:0]  t_rdata;
  task_word_t       t_rd;

  logic             q_we;
  logic [QA_W-1:0]  q_waddr;
  logic [PTR_W-1:0] q_wdata;
  logic [QA_W-1:0]  q_raddr;
  logic [PTR_W-1:0] q_rdata;
  logic [PTR_W-1:0] q_slot;

  logic [PRIORITY_LEVELS-1:0] nonempty;
  logic [LVL_W-1:0]           pick_sel;

  logic [ID_W-1:0]    cur_m1;
  logic [ID_W-1:0]    tid_m1;
  logic               room;
  logic               tid_ok;
  logic [ID_W-1:0]    next_id;
  logic               sw_go;
  logic               expired;
  task_word_t         tick_word;
  logic               cfg_wr;
  logic [LVL_W-1:0]   prio_sat;

  function automatic logic [QA_W-1:0] qaddr(input logic [LVL_W-1:0] lvl,
                                            input logic [PTR_W-1:0] ptr);
    qaddr = QA_W'(lvl) * QA_W'(MAX_TASKS) + QA_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    ptr_inc = (ptr == PTR_W'(MAX_TASKS - 1)) ? '0 : ptr + 1'b1;
  endfunction

  prrs_ram #(.WIDTH(TW_W), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  prrs_ram #(.WIDTH(PTR_W), .DEPTH(PRIORITY_LEVELS * MAX_TASKS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  always_comb begin
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      nonempty[i] = (fill[i] != '0);
    end
  end

  prrs_level_pick #(.LEVELS(PRIORITY_LEVELS)) u_level_pick (
    .nonempty (nonempty),
    .level    (pick_sel)
  );

  assign in_ready = (state == S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - SLICE_W){1'b0}}, slice_reload};

  assign prio_sat = (32'(priority_req) > PRIORITY_LEVELS - 1) ? LVL_W'(PRIORITY_LEVELS - 1)
                                                               : LVL_W'(priority_req);

  assign cur_m1 = current - 1'b1;
  assign tid_m1 = tid_r - 1'b1;
  assign room = (slot_count < ID_W'(MAX_TASKS));
  assign tid_ok = (tid_r != '0) && (tid_r <= slot_count);

  always_comb begin
    if (rd_init) begin
      t_rd.state = TS_READY;
      t_rd.slice = RELOAD_AT_RESET;
      t_rd.run = '0;
    end else begin
      t_rd = task_word_t'(t_rdata);
    end
  end

  assign q_slot = pick_init ? '0 : q_rdata;
  assign next_id = ID_W'(q_slot) + 1'b1;
  assign sw_go = (next_id != current);

  assign expired = (t_rd.slice <= 8'd1);
  always_comb begin
    tick_word.state = t_rd.state;
    tick_word.run = t_rd.run + 1'b1;
    tick_word.slice = expired ? slice_reload : t_rd.slice - 1'b1;
  end

  // Memory ports. The sequencer never reads and writes one entry in the same
  // cycle, so no forwarding is needed.
  always_comb begin
    t_we = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = '0;
    q_we = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    q_raddr = '0;
    case (state)
      S_DECODE: begin
        case (op_r)
          OP_CREATE: begin
            if (room) begin
              t_we = 1'b1;
              t_waddr = slot_count[PTR_W-1:0];
              t_wdata.state = TS_READY;
              t_wdata.slice = slice_reload;
              t_wdata.run = '0;
              q_we = 1'b1;
              q_waddr = qaddr(prio_r, tail[prio_r]);
              q_wdata = slot_count[PTR_W-1:0];
            end
          end
          OP_TERMINATE: t_raddr = tid_m1[PTR_W-1:0];
          OP_TICK: t_raddr = cur_m1[PTR_W-1:0];
          default: t_raddr = '0;
        endcase
      end
      S_TERM_WR: begin
        t_we = 1'b1;
        t_waddr = tid_m1[PTR_W-1:0];
        t_wdata = t_rd;
        t_wdata.state = TS_TERMINATED;
      end
      S_TICK_WR: begin
        t_we = 1'b1;
        t_waddr = cur_m1[PTR_W-1:0];
        t_wdata = tick_word;
      end
      S_PICK: q_raddr = qaddr(pick_sel, head[pick_sel]);
      S_ROTATE: begin
        q_we = 1'b1;
        q_waddr = qaddr(pick_lvl, tail[pick_lvl]);
        q_wdata = q_slot;
        t_raddr = (current != '0) ? cur_m1[PTR_W-1:0] : q_slot;
      end
      S_OLD_WR: begin
        t_we = 1'b1;
        t_waddr = cur_m1[PTR_W-1:0];
        t_wdata = t_rd;
        t_wdata.state = (t_rd.state == TS_TERMINATED) ? TS_TERMINATED : TS_READY;
        t_raddr = nxt_slot;
      end
      S_NEW_WR: begin
        t_we = 1'b1;
        t_waddr = nxt_slot;
        t_wdata = t_rd;
        t_wdata.state = TS_RUNNING;
      end
      default: t_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      slice_reload <= RELOAD_AT_RESET;
      slot_count <= ID_W'(1);
      current <= '0;
      switch_count <= '0;
      t0_written <= 1'b0;
      q0_written <= 1'b0;
      rd_init <= 1'b0;
      pick_init <= 1'b0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= (i == 0) ? PTR_W'(1) : '0;
        fill[i] <= (i == 0) ? ID_W'(1) : '0;
      end
    end else begin
      if (cfg_wr && !paddr[2]) begin
        slice_reload <= pwdata[SLICE_W-1:0];
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (t_we && t_waddr == '0) begin
        t0_written <= 1'b1;
      end
      if (q_we && q_waddr == '0) begin
        q0_written <= 1'b1;
      end
      rd_init <= (t_raddr == '0) && !t0_written;
      pick_init <= (q_raddr == '0) && !q0_written;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= op_t'(operation);
            prio_r <= prio_sat;
            tid_r <= task_id;
            created_r <= '0;
            status_r <= STATUS_OK;
            sw_r <= 1'b0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (op_r)
            OP_CREATE: begin
              if (room) begin
                tail[prio_r] <= ptr_inc(tail[prio_r]);
                fill[prio_r] <= fill[prio_r] + 1'b1;
                slot_count <= slot_count + 1'b1;
                created_r <= slot_count + 1'b1;
              end else begin
                status_r <= STATUS_FULL;
              end
              state <= S_DONE;
            end
            OP_TERMINATE: begin
              if (tid_ok) begin
                state <= S_TERM_WR;
              end else begin
                status_r <= STATUS_NOT_FOUND;
                state <= S_DONE;
              end
            end
            OP_TICK: state <= (current != '0) ? S_TICK_WR : S_DONE;
            default: state <= S_PICK;
          endcase
        end
        S_TERM_WR: state <= S_DONE;
        S_TICK_WR: state <= expired ? S_PICK : S_DONE;
        S_PICK: begin
          pick_lvl <= pick_sel;
          state <= S_ROTATE;
        end
        S_ROTATE: begin
          head[pick_lvl] <= ptr_inc(head[pick_lvl]);
          tail[pick_lvl] <= ptr_inc(tail[pick_lvl]);
          nxt_slot <= q_slot;
          if (!sw_go) begin
            state <= S_DONE;
          end else if (current != '0) begin
            state <= S_OLD_WR;
          end else begin
            state <= S_NEW_WR;
          end
        end
        S_OLD_WR: state <= S_NEW_WR;
        S_NEW_WR: begin
          current <= ID_W'(nxt_slot) + 1'b1;
          switch_count <= switch_count + 1'b1;
          sw_r <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            created_id <= created_r;
            running_id <= current;
            switched <= sw_r;
            status <= status_r;
            switch_total <= switch_count;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import prrs_pkg::*;

  localparam int MAX_TASKS = 256;
  localparam int LEVELS = 4;
  localparam int ID_W = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] SLICE_RELOAD_ADDR = 3'd0;
  localparam int SCRIPT_LEN = 22;

  typedef struct packed {
    logic [ID_W-1:0] created;
    logic [ID_W-1:0] running;
    logic            sw;
    status_t         stat;
    logic [31:0]     total;
  } sched_result_t;

  typedef struct packed {
    op_t             op;
    logic [1:0]      prio;
    logic [ID_W-1:0] tid;
    logic            typed;
    sched_result_t   res;
  } sched_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = 2'd0;
  logic [1:0] priority_req = 2'd0;
  logic [ID_W-1:0] task_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ID_W-1:0] created_id;
  logic [ID_W-1:0] running_id;
  logic switched;
  logic [1:0] status;
  logic [31:0] switch_total;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Scheduler image kept by the testbench.
  tstate_t     task_st [MAX_TASKS];
  logic [7:0]  slice_cnt [MAX_TASKS];
  logic [31:0] ticks_run [MAX_TASKS];
  logic [7:0]  ring [LEVELS][MAX_TASKS];
  logic [7:0]  ring_head [LEVELS];
  logic [7:0]  ring_tail [LEVELS];
  logic [8:0]  ring_count [LEVELS];
  logic [8:0]  task_count;
  logic [ID_W-1:0] running;
  logic [31:0] switches;
  logic [7:0]  reload;

  sched_result_t awaited_results [$];
  sched_row_t script_rows [SCRIPT_LEN];
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_ask = 1'b0;
  bit quiet = 1'b0;

  priority_round_robin_scheduler_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .priority_req(priority_req), .task_id(task_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .created_id(created_id), .running_id(running_id), .switched(switched),
    .status(status), .switch_total(switch_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s is 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic void reset_image();
    for (int i = 0; i < MAX_TASKS; i++) begin
      task_st[i] = TS_TERMINATED;
      slice_cnt[i] = '0;
      ticks_run[i] = '0;
    end
    for (int l = 0; l < LEVELS; l++) begin
      ring_head[l] = '0;
      ring_tail[l] = '0;
      ring_count[l] = '0;
    end
    reload = RELOAD_AT_RESET;
    task_st[0] = TS_READY;
    slice_cnt[0] = reload;
    ring[0][0] = 8'd0;
    ring_tail[0] = 8'd1;
    ring_count[0] = 9'd1;
    task_count = 9'd1;
    running = '0;
    switches = '0;
  endfunction

  // Rotates the head of the highest occupied level to its tail and switches to it unless it is already running.
  function automatic logic rotate_and_switch();
    logic [ID_W-1:0] next;
    logic [7:0] h;
    logic found;
    next = 9'd1;
    found = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (!found && ring_count[l] != 0) begin
        found = 1'b1;
        h = ring_head[l];
        next = {1'b0, ring[l][h]} + 9'd1;
        ring_head[l] = h + 8'd1;
        ring[l][ring_tail[l]] = ring[l][h];
        ring_tail[l] = ring_tail[l] + 8'd1;
      end
    end
    if (next == running || next < 1 || next > task_count) return 1'b0;
    if (running >= 1 && running <= task_count) begin
      if (task_st[running - 1] != TS_TERMINATED) task_st[running - 1] = TS_READY;
    end
    task_st[next - 1] = TS_RUNNING;
    running = next;
    switches = switches + 32'd1;
    return 1'b1;
  endfunction

  function automatic sched_result_t schedule_item(input op_t op, input logic [1:0] prio,
                                                  input logic [ID_W-1:0] tid);
    sched_result_t r;
    logic [7:0] slot;
    r = '0;
    case (op)
      OP_CREATE: begin
        if (task_count >= MAX_TASKS) begin
          r.stat = STATUS_FULL;
        end else begin
          slot = task_count[7:0];
          task_st[slot] = TS_READY;
          slice_cnt[slot] = reload;
          ticks_run[slot] = '0;
          ring[prio][ring_tail[prio]] = slot;
          ring_tail[prio] = ring_tail[prio] + 8'd1;
          ring_count[prio] = ring_count[prio] + 9'd1;
          task_count = task_count + 9'd1;
          r.created = task_count;
        end
      end
      OP_TERMINATE: begin
        if (tid >= 1 && tid <= task_count) task_st[tid - 1] = TS_TERMINATED;
        else r.stat = STATUS_NOT_FOUND;
      end
      OP_TICK: begin
        if (running >= 1 && running <= task_count) begin
          ticks_run[running - 1] = ticks_run[running - 1] + 32'd1;
          if (slice_cnt[running - 1] <= 8'd1) begin
            slice_cnt[running - 1] = reload;
            r.sw = rotate_and_switch();
          end else begin
            slice_cnt[running - 1] = slice_cnt[running - 1] - 8'd1;
          end
        end
      end
      default: begin
        r.sw = rotate_and_switch();
      end
    endcase
    r.running = running;
    r.total = switches;
    return r;
  endfunction

  task automatic offer(input op_t op, input logic [1:0] prio, input logic [ID_W-1:0] tid,
                       input logic typed, input sched_result_t typed_res);
    int gap;
    sched_result_t res;
    @(negedge clk);
    gap = (quiet || $urandom_range(99) >= 15) ? 0 : $urandom_range(6, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    priority_req <= prio;
    task_id <= tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = schedule_item(op, prio, tid);
    awaited_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // Writes the slice length and reads it back; only called while the block is idle.
  task automatic write_reload(input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SLICE_RELOAD_ADDR;
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    reload = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== value) report_mismatch("slice_reload readback", prdata, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(input int count);
    op_t op;
    logic [1:0] prio;
    logic [ID_W-1:0] tid;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      prio = 2'($urandom_range(3));
      tid = ID_W'($urandom_range(511));
      if (pick < 25) begin
        op = OP_CREATE;
      end else if (pick < 40) begin
        op = OP_TERMINATE;
        // Mostly live ids; the rest is any 9-bit value.
        if ($urandom_range(3) != 0) tid = ID_W'($urandom_range(task_count, 1));
      end else if (pick < 80) begin
        op = OP_TICK;
      end else begin
        op = OP_YIELD;
      end
      offer(op, prio, tid, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result word with nothing awaited, running_id", running_id, 0);
      end else begin
        want = awaited_results.pop_front();
        if (created_id !== want.created) report_mismatch("created_id", created_id, want.created);
        if (running_id !== want.running) report_mismatch("running_id", running_id, want.running);
        if (switched !== want.sw) report_mismatch("switched", switched, want.sw);
        if (status !== want.stat) report_mismatch("status", status, want.stat);
        if (switch_total !== want.total)
          report_mismatch("switch_total", switch_total, want.total);
      end
    end
  end

  initial begin
    // Rows typed with an expectation cover reset-state, error, create, terminate, tick and
    // yield cases; the rest follow the image.
    script_rows = '{
      '{OP_TICK,      2'd0, 9'd0,   1'b1, '{9'd0, 9'd0, 1'b0, STATUS_OK, 32'd0}},
      '{OP_TERMINATE, 2'd0, 9'd0,   1'b1, '{9'd0, 9'd0, 1'b0, STATUS_NOT_FOUND, 32'd0}},
      '{OP_TERMINATE, 2'd3, 9'd2,   1'b1, '{9'd0, 9'd0, 1'b0, STATUS_NOT_FOUND, 32'd0}},
      '{OP_TERMINATE, 2'd0, 9'd511, 1'b1, '{9'd0, 9'd0, 1'b0, STATUS_NOT_FOUND, 32'd0}},
      '{OP_YIELD,     2'd0, 9'd0,   1'b1, '{9'd0, 9'd1, 1'b1, STATUS_OK, 32'd1}},
      '{OP_YIELD,     2'd3, 9'd511, 1'b1, '{9'd0, 9'd1, 1'b0, STATUS_OK, 32'd1}},
      '{OP_TICK,      2'd0, 9'd0,   1'b1, '{9'd0, 9'd1, 1'b0, STATUS_OK, 32'd1}},
      '{OP_CREATE,    2'd0, 9'd0,   1'b1, '{9'd2, 9'd1, 1'b0, STATUS_OK, 32'd1}},
      '{OP_CREATE,    2'd3, 9'd0,   1'b1, '{9'd3, 9'd1, 1'b0, STATUS_OK, 32'd1}},
      '{OP_CREATE,    2'd2, 9'd0,   1'b1, '{9'd4, 9'd1, 1'b0, STATUS_OK, 32'd1}},
      '{OP_CREATE,    2'd1, 9'd0,   1'b1, '{9'd5, 9'd1, 1'b0, STATUS_OK, 32'd1}},
      '{OP_YIELD,     2'd0, 9'd0,   1'b1, '{9'd0, 9'd3, 1'b1, STATUS_OK, 32'd2}},
      '{OP_TERMINATE, 2'd0, 9'd3,   1'b1, '{9'd0, 9'd3, 1'b0, STATUS_OK, 32'd2}},
      '{OP_TICK,      2'd0, 9'd0,   1'b1, '{9'd0, 9'd3, 1'b0, STATUS_OK, 32'd2}},
      '{OP_TERMINATE, 2'd0, 9'd6,   1'b1, '{9'd0, 9'd3, 1'b0, STATUS_NOT_FOUND, 32'd2}},
      '{OP_CREATE,    2'd3, 9'd0,   1'b1, '{9'd6, 9'd3, 1'b0, STATUS_OK, 32'd2}},
      '{OP_YIELD,     2'd0, 9'd0,   1'b0, '0},
      '{OP_YIELD,     2'd0, 9'd0,   1'b0, '0},
      '{OP_YIELD,     2'd0, 9'd0,   1'b0, '0},
      '{OP_TERMINATE, 2'd0, 9'd256, 1'b0, '0},
      '{OP_TERMINATE, 2'd0, 9'd1,   1'b0, '0},
      '{OP_TICK,      2'd2, 9'd255, 1'b0, '0}
    };
    reset_image();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script_rows[i])
      offer(script_rows[i].op, script_rows[i].prio, script_rows[i].tid,
            script_rows[i].typed, script_rows[i].res);
    drain();

    // Shortest slice: once a task's slice has been loaded from it, each of its ticks expires.
    write_reload(8'd1);
    quiet = 1'b1;
    run_random(100);
    quiet = 1'b0;
    run_random(200);
    drain();

    // Longest slice, with a long receiver hold-off in the middle.
    write_reload(8'd255);
    run_random(150);
    hold_ask = 1'b1;
    run_random(150);
    drain();

    write_reload(8'($urandom_range(254, 2)));
    run_random(200);
    drain();
    run_random(250);
    drain();

    write_reload(RELOAD_AT_RESET);
    run_random(450);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
